// ===== src/indexed_list_engine_macros.svh =====
// Assertion macros shared by the indexed list engine RTL.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define ILST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilst assertion failed");

// Next-cycle implication, checked out of reset.
`define ILST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilst assertion failed");

`else

`define ILST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ILST_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ilst_pkg.sv =====
// Types, constants and codes of the indexed list engine.
package ilst_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int POS_W  = 4;
    localparam int LEN_W  = 5;
    localparam int STAT_W = 3;
    localparam int TYPE_W = 4;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_PUSH_FRONT  = 4'd0,
        REQ_PUSH_BACK   = 4'd1,
        REQ_INS_AFTER   = 4'd2,
        REQ_INS_BEFORE  = 4'd3,
        REQ_POP_FRONT   = 4'd4,
        REQ_POP_BACK    = 4'd5,
        REQ_REMOVE_AT   = 4'd6,
        REQ_FIND        = 4'd7,
        REQ_DUMP        = 4'd8
    } ilst_req_e;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOTFOUND  = 3'd4
    } ilst_status_e;

    typedef struct packed {
        logic [TYPE_W-1:0]       req_type;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } ilst_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] item_value;
        logic [POS_W-1:0]        item_position;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } ilst_rsp_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic [IDX_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } ilst_cmd_t;

    // Scan unit status toward the control logic.
    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
        logic             last;
    } ilst_pick_t;

endpackage

// ===== src/ilst_req_if.sv =====
// Request channel: valid/ready handshake carrying one list request.
interface ilst_req_if;
    import ilst_pkg::*;

    logic      valid;
    logic      ready;
    ilst_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/ilst_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one list result.
interface ilst_rsp_if;
    import ilst_pkg::*;

    logic      valid;
    logic      ready;
    ilst_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/ilst_cell.sv =====
// One list element: shifts toward its neighbors on insert and remove.
module ilst_cell (
    input  logic                           clk,
    input  logic [ilst_pkg::IDX_W-1:0]     idx,
    input  ilst_pkg::ilst_cmd_t            cmd,
    input  logic signed [ilst_pkg::VAL_W-1:0] left,
    input  logic signed [ilst_pkg::VAL_W-1:0] right,
    output logic signed [ilst_pkg::VAL_W-1:0] data,
    output logic                           match
);
    import ilst_pkg::*;

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (idx > cmd.pos)
            begin
                data_next = left;
            end
            else if (idx == cmd.pos)
            begin
                data_next = cmd.value;
            end
        end
        else if (cmd.rem && (idx >= cmd.pos))
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == cmd.value);
endmodule

// ===== src/ilst_scan.sv =====
// Result scanner: walks a position mask front first, one position per advance.
module ilst_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [ilst_pkg::DEPTH-1:0]  load_mask,
    input  logic                        advance,
    output ilst_pkg::ilst_pick_t        pick
);
    import ilst_pkg::*;

    logic [DEPTH-1:0] mask_reg;
    logic [DEPTH-1:0] mask_next;
    logic [DEPTH-1:0] sel;
    logic [DEPTH-1:0] rest;
    logic [IDX_W-1:0] idx;
    logic             found;

    // lowest set bit
    always_comb
    begin
        sel   = '0;
        idx   = '0;
        found = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                sel[i] = 1'b1;
                idx    = IDX_W'(i);
                found  = 1'b1;
            end
        end
    end

    assign rest = mask_reg & ~sel;

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = load_mask;
        end
        else if (advance)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign pick.busy = found;
    assign pick.idx  = idx;
    assign pick.last = (rest == '0);
endmodule

// ===== src/indexed_list_engine.sv =====
// Top level of the indexed list engine: request decode, cell chain and result register.
// Ordered list of up to DEPTH signed 32-bit values kept in a chain of cells, position 0
// at the front. Inserts and removals are decoded and applied in the cycle the request
// transfers, the cells from the target position back shifting by one cell in that cycle,
// and the single result is loaded into the output register at the same edge. Find and
// dump that have results load a position mask into the scanner and then emit one result
// per cycle while the sink is ready, through the single output register, front first,
// up to DEPTH results. A new request is taken only once the previous one has loaded its
// last result and the output register is free or being drained. Request types 9 to 15
// are taken and produce no result.
`include "indexed_list_engine_macros.svh"

module indexed_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    ilst_req_if.sink    req,
    ilst_rsp_if.source  rsp
);
    import ilst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    ilst_rsp_t           rsp_data_reg;
    ilst_rsp_t           rsp_data_next;

    logic                req_fire;
    logic                can_load;
    logic                load_scan;
    logic                empty;
    logic                full;
    logic                pos_ok;
    logic                do_ins;
    logic                do_rem;
    logic                emit;
    logic                start_scan;
    logic [IDX_W-1:0]    p;
    ilst_status_e        st;
    logic [DEPTH-1:0]    below;
    logic [DEPTH-1:0]    match;
    logic [DEPTH-1:0]    scan_mask;
    logic [IDX_W-1:0]    rd_idx;
    logic signed [VAL_W-1:0] rd_data;
    logic signed [VAL_W-1:0] cell_data [DEPTH];
    ilst_cmd_t           cmd;
    ilst_pick_t          pick;
    ilst_rsp_t           single_rsp;

    assign can_load  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && can_load;
    assign req_fire  = req.valid && req.ready;
    assign load_scan = (state_reg == S_SCAN) && can_load;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign pos_ok = (CMP_W'(req.data.position) < CMP_W'(count_reg));

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            below[i] = (CMP_W'(i) < CMP_W'(count_reg));
        end
    end

    // request decode
    always_comb
    begin
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        emit       = 1'b0;
        start_scan = 1'b0;
        p          = '0;
        st         = ST_OK;
        scan_mask  = below;
        unique case (req.data.req_type) inside
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INS_AFTER, REQ_INS_BEFORE:
            begin
                emit = 1'b1;
                if ((req.data.req_type == REQ_INS_AFTER ||
                     req.data.req_type == REQ_INS_BEFORE) && empty)
                begin
                    st = ST_EMPTY;
                end
                else if (full)
                begin
                    st = ST_FULL;
                end
                else if ((req.data.req_type == REQ_INS_AFTER ||
                          req.data.req_type == REQ_INS_BEFORE) && !pos_ok)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    do_ins = 1'b1;
                    if (req.data.req_type == REQ_PUSH_BACK)
                    begin
                        p = IDX_W'(count_reg);
                    end
                    else if (req.data.req_type == REQ_INS_AFTER)
                    begin
                        p = IDX_W'(req.data.position) + IDX_W'(1);
                    end
                    else if (req.data.req_type == REQ_INS_BEFORE)
                    begin
                        p = IDX_W'(req.data.position);
                    end
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE_AT:
            begin
                emit = 1'b1;
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (req.data.req_type == REQ_REMOVE_AT && !pos_ok)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    do_rem = 1'b1;
                    if (req.data.req_type == REQ_POP_BACK)
                    begin
                        p = IDX_W'(count_reg - CNT_W'(1));
                    end
                    else if (req.data.req_type == REQ_REMOVE_AT)
                    begin
                        p = IDX_W'(req.data.position);
                    end
                end
            end
            REQ_FIND, REQ_DUMP:
            begin
                if (req.data.req_type == REQ_FIND)
                begin
                    scan_mask = below & match;
                end
                if (empty)
                begin
                    emit = 1'b1;
                    st   = ST_EMPTY;
                end
                else if (scan_mask == '0)
                begin
                    emit = 1'b1;
                    st   = ST_NOTFOUND;
                end
                else
                begin
                    start_scan = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign cmd.ins   = req_fire && do_ins;
    assign cmd.rem   = req_fire && do_rem;
    assign cmd.pos   = p;
    assign cmd.value = req.data.value;

    // cell chain: each cell sees its front and back neighbors
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_w;
        logic signed [VAL_W-1:0] right_w;

        if (g == 0)
        begin : g_front
            assign left_w = cell_data[g];
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_back
            assign right_w = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        ilst_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(g)),
            .cmd   (cmd),
            .left  (left_w),
            .right (right_w),
            .data  (cell_data[g]),
            .match (match[g])
        );
    end

    ilst_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (req_fire && start_scan),
        .load_mask (scan_mask),
        .advance   (load_scan),
        .pick      (pick)
    );

    // single read port: scan position while scanning, removal position otherwise
    assign rd_idx  = (state_reg == S_SCAN) ? pick.idx : p;
    assign rd_data = cell_data[rd_idx];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        single_rsp.status        = st;
        single_rsp.item_value    = do_ins ? req.data.value : (do_rem ? rd_data : '0);
        single_rsp.item_position = (do_ins || do_rem) ? POS_W'(p) : '0;
        single_rsp.length        = LEN_W'(count_next);
        single_rsp.last          = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && emit)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = single_rsp;
                end
                if (req_fire && start_scan)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (load_scan)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.status        = ST_OK;
                    rsp_data_next.item_value    = rd_data;
                    rsp_data_next.item_position = POS_W'(pick.idx);
                    rsp_data_next.length        = LEN_W'(count_reg);
                    rsp_data_next.last          = pick.last;
                    if (pick.last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    `ILST_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ILST_ASSERT_IMP(a_scan_has_work, clk, rst_n, state_reg == S_SCAN, pick.busy)
    `ILST_ASSERT_NXT(a_scan_ends, clk, rst_n, load_scan && pick.last, state_reg == S_IDLE)
    `ILST_ASSERT_NXT(a_count_holds, clk, rst_n, !req_fire, $stable(count_reg))
endmodule

// ===== tb/sv/ilst_result_checker.sv =====
// Result checker for the indexed list engine: predicts every result and compares transfers.
module ilst_result_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    ilst_req_if                     req_mon,
    ilst_rsp_if                     rsp_mon,
    output int                      fail_count,
    output int                      pending,
    output logic [ilst_pkg::LEN_W-1:0] fill_level
);
    timeunit 1ns;
    timeprecision 1ps;

    import ilst_pkg::*;

    localparam int MAX_PRINTS = 100;

    // Predicted list contents and results still owed by the block.
    logic signed [VAL_W-1:0] cells [DEPTH];
    int                      held;
    ilst_rsp_t               results_due [$];
    ilst_rsp_t               got;
    ilst_rsp_t               want;

    initial fail_count = 0;

    task automatic report(input string what, input logic [31:0] seen, input logic [31:0] due);
        if (fail_count < MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, seen, due);
        fail_count++;
    endtask

    function automatic void owe(input ilst_status_e st, input logic signed [VAL_W-1:0] v,
                                input int pos, input bit fin);
        ilst_rsp_t r;
        logic [31:0] pos_bits;
        logic [31:0] len_bits;
        pos_bits        = pos;
        len_bits        = held;
        r.status        = st;
        r.item_value    = v;
        r.item_position = pos_bits[POS_W-1:0];
        r.length        = len_bits[LEN_W-1:0];
        r.last          = fin;
        results_due.push_back(r);
    endfunction

    function automatic void apply_request(input ilst_req_t rq);
        int  p;
        int  hits;
        int  k;
        bit  at_pos;
        logic signed [VAL_W-1:0] v;
        at_pos = (rq.req_type == REQ_INS_AFTER) || (rq.req_type == REQ_INS_BEFORE);
        case (rq.req_type) inside
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INS_AFTER, REQ_INS_BEFORE:
            begin
                // empty beats full beats range for positional inserts
                if (at_pos && held == 0)
                    owe(ST_EMPTY, '0, 0, 1'b1);
                else if (held >= DEPTH)
                    owe(ST_FULL, '0, 0, 1'b1);
                else if (at_pos && int'(rq.position) >= held)
                    owe(ST_RANGE, '0, 0, 1'b1);
                else begin
                    if (rq.req_type == REQ_PUSH_FRONT)
                        p = 0;
                    else if (rq.req_type == REQ_PUSH_BACK)
                        p = held;
                    else if (rq.req_type == REQ_INS_AFTER)
                        p = int'(rq.position) + 1;
                    else
                        p = int'(rq.position);
                    for (int i = held; i > p; i--)
                        cells[i] = cells[i-1];
                    cells[p] = rq.value;
                    held++;
                    owe(ST_OK, rq.value, p, 1'b1);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE_AT:
            begin
                if (held == 0)
                    owe(ST_EMPTY, '0, 0, 1'b1);
                else if (rq.req_type == REQ_REMOVE_AT && int'(rq.position) >= held)
                    owe(ST_RANGE, '0, 0, 1'b1);
                else begin
                    if (rq.req_type == REQ_POP_FRONT)
                        p = 0;
                    else if (rq.req_type == REQ_POP_BACK)
                        p = held - 1;
                    else
                        p = int'(rq.position);
                    v = cells[p];
                    for (int i = p; i + 1 < held; i++)
                        cells[i] = cells[i+1];
                    held--;
                    owe(ST_OK, v, p, 1'b1);
                end
            end
            REQ_FIND:
            begin
                if (held == 0)
                    owe(ST_EMPTY, '0, 0, 1'b1);
                else begin
                    hits = 0;
                    for (int i = 0; i < held; i++)
                        if (cells[i] == rq.value)
                            hits++;
                    if (hits == 0)
                        owe(ST_NOTFOUND, '0, 0, 1'b1);
                    else begin
                        k = 0;
                        for (int i = 0; i < held; i++)
                            if (cells[i] == rq.value) begin
                                k++;
                                owe(ST_OK, rq.value, i, k == hits);
                            end
                    end
                end
            end
            REQ_DUMP:
            begin
                if (held == 0)
                    owe(ST_EMPTY, '0, 0, 1'b1);
                else
                    for (int i = 0; i < held; i++)
                        owe(ST_OK, cells[i], i, i + 1 == held);
            end
            default:
            begin
                // undefined types are swallowed without a result
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held = 0;
            results_due.delete();
            pending    <= 0;
            fill_level <= '0;
        end else begin
            // request first: a result of this very request would sit at the back anyway
            if (req_mon.valid && req_mon.ready)
                apply_request(req_mon.data);
            if (rsp_mon.valid && rsp_mon.ready) begin
                got = rsp_mon.data;
                if (results_due.size() == 0)
                    report("unexpected result", got.item_value, '0);
                else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (got.item_value !== want.item_value)
                        report("item_value", got.item_value, want.item_value);
                    if (got.item_position !== want.item_position)
                        report("item_position", 32'(got.item_position),
                               32'(want.item_position));
                    if (got.length !== want.length)
                        report("length", 32'(got.length), 32'(want.length));
                    if (got.last !== want.last)
                        report("last", 32'(got.last), 32'(want.last));
                end
            end
            pending    <= results_due.size();
            fill_level <= held[LEN_W-1:0];
        end
    end

endmodule

// ===== tb/sv/indexed_list_engine_tb.sv =====
// Testbench top for the indexed list engine: clock, reset, request and ready stimulus, verdict.
module indexed_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ilst_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_CYCLES = 200000;
    localparam logic [TYPE_W-1:0] REQ_UNDEF_FIRST = 4'd9;
    localparam logic [TYPE_W-1:0] REQ_UNDEF_LAST  = 4'd15;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   holds_asked  = 0;
    int   holds_served = 0;
    int   cycles       = 0;
    bit   growing      = 1'b1;
    int   fail_count;
    int   pending;
    logic [LEN_W-1:0] fill_level;

    ilst_req_if req_ch ();
    ilst_rsp_if rsp_ch ();

    indexed_list_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ilst_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req_ch),
        .rsp_mon    (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .fill_level (fill_level)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sink side: random stalls, plus long hold-offs on request from the stimulus.
    initial
    begin
        int left;
        left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (left > 0) begin
                left--;
                rsp_ch.ready <= 1'b0;
            end else if (holds_served != holds_asked) begin
                holds_served++;
                left = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one request and returns in the step of its transfer.
    task automatic send_req(input logic [TYPE_W-1:0] kind, input logic signed [VAL_W-1:0] v,
                            input logic [POS_W-1:0] p);
        ilst_req_t item;
        item.req_type = kind;
        item.value    = v;
        item.position = p;
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Mostly a few recurring values so that finds hit, sometimes anything.
    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        if ($urandom_range(3) == 0)
            v = $urandom;
        else
            case ($urandom_range(5))
                0:       v = 32'sh7FFFFFFF;
                1:       v = 32'sh80000000;
                2:       v = 32'sh00000000;
                3:       v = -32'sd1;
                4:       v = 32'sd5;
                default: v = 32'sh5A5A0F0F;
            endcase
        return v;
    endfunction

    // Random walk that swings the list between nearly empty and full.
    task automatic random_items(input int n);
        int sent;
        int lvl;
        int r;
        logic [TYPE_W-1:0]       kind;
        logic [POS_W-1:0]        p;
        logic signed [VAL_W-1:0] v;
        sent = 0;
        while (sent < n) begin
            // level lags one transfer behind; close enough for steering
            lvl = int'(fill_level);
            if (lvl >= DEPTH - 1)
                growing = 1'b0;
            else if (lvl <= 1)
                growing = 1'b1;
            r = $urandom_range(99);
            v = pick_value();
            p = (lvl > 0) ? POS_W'($urandom_range(lvl - 1)) : '0;
            if ($urandom_range(9) == 0)
                p = POS_W'($urandom_range(15));
            if (r < 4)
                kind = TYPE_W'($urandom_range(int'(REQ_UNDEF_LAST), int'(REQ_UNDEF_FIRST)));
            else if (r < 12) begin
                kind = TYPE_W'($urandom_range(int'(REQ_DUMP), int'(REQ_PUSH_FRONT)));
                v    = $urandom;
                p    = POS_W'($urandom_range(15));
            end else if (r < 24)
                kind = REQ_FIND;
            else if (r < 30)
                kind = REQ_DUMP;
            else if ((r < 85) == growing)
                kind = TYPE_W'($urandom_range(int'(REQ_INS_BEFORE), int'(REQ_PUSH_FRONT)));
            else
                kind = TYPE_W'($urandom_range(int'(REQ_REMOVE_AT), int'(REQ_POP_FRONT)));
            send_req(kind, v, p);
            if (r >= 4)
                sent++;
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // finds, dumps, removals and a positional insert on an empty list
        send_req(REQ_DUMP, 32'sd0, 4'd0);
        send_req(REQ_FIND, 32'sd5, 4'd0);
        send_req(REQ_POP_FRONT, 32'sd0, 4'd0);
        send_req(REQ_REMOVE_AT, 32'sd0, 4'd15);
        send_req(REQ_INS_BEFORE, 32'sd7, 4'd0);

        send_req(REQ_PUSH_BACK, 32'sh7FFFFFFF, 4'd0);
        send_req(REQ_PUSH_FRONT, 32'sh80000000, 4'd15);
        send_req(REQ_PUSH_BACK, 32'sd0, 4'd0);
        send_req(REQ_PUSH_BACK, -32'sd1, 4'd0);
        send_req(REQ_INS_AFTER, 32'sd5, 4'd3);
        send_req(REQ_INS_BEFORE, 32'sd5, 4'd0);
        send_req(REQ_INS_AFTER, 32'sd9, 4'd15);
        send_req(REQ_REMOVE_AT, 32'sd0, 4'd6);
        // two matches, then none
        send_req(REQ_FIND, 32'sd5, 4'd0);
        send_req(REQ_FIND, 32'sh12345678, 4'd0);
        send_req(REQ_DUMP, 32'sd0, 4'd0);
        send_req(REQ_REMOVE_AT, 32'sd0, 4'd5);
        send_req(REQ_POP_FRONT, 32'sd0, 4'd0);
        send_req(REQ_POP_BACK, 32'sd0, 4'd0);
        send_req(REQ_UNDEF_FIRST, 32'sd0, 4'd0);

        // long hold-off on the sink while requests keep coming; fills the list past full
        holds_asked <= holds_asked + 1;
        for (int i = 0; i < 15; i++)
            send_req(REQ_PUSH_BACK, pick_value(), 4'd0);
        send_req(REQ_PUSH_FRONT, 32'sd1, 4'd0);
        send_req(REQ_INS_AFTER, 32'sd1, 4'd15);
        send_req(REQ_INS_BEFORE, 32'sd1, 4'd0);
        send_req(REQ_FIND, -32'sd1, 4'd0);
        send_req(REQ_DUMP, 32'sd0, 4'd0);
        send_req(REQ_REMOVE_AT, 32'sd0, 4'd15);

        idle_pct = 0;
        stall_pct <= 0;
        random_items(15);
        idle_pct = 63;
        random_items(15);
        idle_pct = 0;
        stall_pct <= 63;
        random_items(15);
        idle_pct = 19;
        stall_pct <= 19;
        random_items(15);
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ilst_pkg.sv
src/ilst_req_if.sv
src/ilst_rsp_if.sv
src/ilst_cell.sv
src/ilst_scan.sv
src/indexed_list_engine.sv
tb/sv/ilst_result_checker.sv
tb/sv/indexed_list_engine_tb.sv
